@@ hdl/mpst_pkg.sv @@
package mpst_pkg;

    localparam int CNT_W   = 11;
    localparam int SUM_W   = 48;
    localparam int DATA_W  = 32;
    localparam int RANK_W  = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_LEAF_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZETA       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ETA        = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0]        cnt;
        logic signed [SUM_W-1:0] total;
        logic signed [SUM_W-1:0] best;
        logic                    cut;
    } node_t;

    typedef enum logic [4:0] {
        ST_BOOT,
        ST_IDLE,
        ST_CLR,
        ST_ETA_SET,
        ST_ETA,
        ST_INS_SET,
        ST_LEAF_RD,
        ST_INS_WR,
        ST_LST_WR,
        ST_UP_RD,
        ST_UP_WR,
        ST_FIND_SET,
        ST_FIND_RD,
        ST_FIND_STEP,
        ST_ROOT_RD,
        ST_ROOT_CHK,
        ST_DOWN_RD,
        ST_DOWN_STEP,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR,
        OP_ETA_SET,
        OP_ETA,
        OP_INS_SET,
        OP_LEAF_RD,
        OP_INS_WR,
        OP_LST_WR,
        OP_UP_RD,
        OP_UP_WR,
        OP_FIND_SET,
        OP_FIND_RD,
        OP_FIND_STEP,
        OP_LST_SET,
        OP_ROOT_RD,
        OP_ROOT_CHK,
        OP_DOWN_RD,
        OP_DOWN_STEP,
        OP_DOWN_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic clr_end;
        logic at_root;
        logic at_leaf;
        logic record;
        logic last;
    } stat_t;

endpackage

@@ hdl/mpst_ctrl.sv @@
module mpst_ctrl
    import mpst_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  first_item,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  res_valid
);

    state_t state_reg, state_next;
    logic   lastph_reg, lastph_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_BOOT;
            lastph_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            lastph_reg <= lastph_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        lastph_next = lastph_reg;
        case (state_reg)
            ST_BOOT:      if (stat.clr_end) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (start)
                begin
                    lastph_next = 1'b0;
                    state_next  = first_item ? ST_CLR : ST_INS_SET;
                end
            end
            ST_CLR:       if (stat.clr_end) state_next = ST_ETA_SET;
            ST_ETA_SET:   state_next = ST_ETA;
            ST_ETA:       if (stat.at_root) state_next = ST_INS_SET;
            ST_INS_SET:   state_next = ST_LEAF_RD;
            ST_LEAF_RD:   state_next = lastph_reg ? ST_LST_WR : ST_INS_WR;
            ST_INS_WR:    state_next = ST_UP_RD;
            ST_LST_WR:    state_next = ST_UP_RD;
            ST_UP_RD:     state_next = ST_UP_WR;
            ST_UP_WR:
            begin
                if (!stat.at_root)
                    state_next = ST_UP_RD;
                else if (stat.last && !lastph_reg)
                    state_next = ST_FIND_SET;
                else
                    state_next = ST_ROOT_RD;
            end
            ST_FIND_SET:
            begin
                lastph_next = 1'b1;
                state_next  = ST_FIND_RD;
            end
            ST_FIND_RD:   state_next = stat.at_leaf ? ST_LEAF_RD : ST_FIND_STEP;
            ST_FIND_STEP: state_next = ST_FIND_RD;
            ST_ROOT_RD:   state_next = ST_ROOT_CHK;
            ST_ROOT_CHK:  state_next = stat.record ? ST_DOWN_RD : ST_DONE;
            ST_DOWN_RD:   state_next = stat.at_leaf ? ST_DONE : ST_DOWN_STEP;
            ST_DOWN_STEP: state_next = ST_DOWN_RD;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op    = OP_NONE;
        busy      = 1'b1;
        res_valid = 1'b0;
        case (state_reg)
            ST_BOOT:      cmd.op = OP_CLR;
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                    cmd.op = OP_LOAD;
            end
            ST_CLR:       cmd.op = OP_CLR;
            ST_ETA_SET:   cmd.op = OP_ETA_SET;
            ST_ETA:       cmd.op = OP_ETA;
            ST_INS_SET:   cmd.op = OP_INS_SET;
            ST_LEAF_RD:   cmd.op = OP_LEAF_RD;
            ST_INS_WR:    cmd.op = OP_INS_WR;
            ST_LST_WR:    cmd.op = OP_LST_WR;
            ST_UP_RD:     cmd.op = OP_UP_RD;
            ST_UP_WR:     cmd.op = OP_UP_WR;
            ST_FIND_SET:  cmd.op = OP_FIND_SET;
            ST_FIND_RD:   cmd.op = stat.at_leaf ? OP_LST_SET : OP_FIND_RD;
            ST_FIND_STEP: cmd.op = OP_FIND_STEP;
            ST_ROOT_RD:   cmd.op = OP_ROOT_RD;
            ST_ROOT_CHK:  cmd.op = OP_ROOT_CHK;
            ST_DOWN_RD:   cmd.op = stat.at_leaf ? OP_DOWN_FIN : OP_DOWN_RD;
            ST_DOWN_STEP: cmd.op = OP_DOWN_STEP;
            ST_DONE:      res_valid = 1'b1;
            default:      cmd.op = OP_NONE;
        endcase
    end

endmodule

@@ hdl/mpst_dp.sv @@
module mpst_dp
    import mpst_pkg::*;
#(
    parameter int LEAVES = 1024
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  cmd_t                                    cmd,
    output stat_t                                   stat,
    input  logic [RANK_W-1:0]                       x_rank,
    input  logic [RANK_W-1:0]                       y_pos,
    input  logic signed [DATA_W-1:0]                loss_value,
    input  logic                                    group_end,
    input  logic                                    first_item,
    input  logic                                    last_item,
    input  logic [$clog2(2**$clog2(LEAVES))-1:0]    n_m1,
    input  logic signed [DATA_W-1:0]                zeta,
    input  logic signed [SUM_W-1:0]                 neg_eta,
    output logic signed [SUM_W-1:0]                 root_best,
    output logic signed [SUM_W-1:0]                 optimum,
    output logic                                    optimum_valid,
    output logic [RANK_W-1:0]                       best_x_rank,
    output logic [RANK_W-1:0]                       best_y_pos,
    output logic                                    done_res
);

    localparam int P     = 2**$clog2(LEAVES);
    localparam int LIW   = $clog2(P);
    localparam int NW    = LIW + 1;
    localparam int NODES = 2 * P - 1;
    localparam logic [NW-1:0] BASE     = NW'(P - 1);
    localparam logic [NW-1:0] LAST_IDX = NW'(NODES - 1);

    node_t mem [NODES];
    node_t rd_a_reg, rd_b_reg;
    logic [NW-1:0] ra, rb, wa;
    logic          we;
    node_t         wd;

    logic [NW-1:0]           ptr_reg, ptr_next;
    logic                    dir_reg, dir_next;
    logic [LIW-1:0]          x_reg;
    logic [RANK_W-1:0]       y_reg;
    logic signed [DATA_W-1:0] loss_reg;
    logic                    gend_reg, last_reg;
    logic signed [SUM_W-1:0] root_reg, bval_reg;
    logic                    found_reg;
    logic [RANK_W-1:0]       bx_reg, by_reg;

    logic [NW-1:0]           parent, lchild, rchild;
    logic [LIW-1:0]          x_clamp, leaf_off, f_leaf;
    logic [CNT_W:0]          csum;
    logic signed [SUM_W-1:0] lb, rbest, delta, leaf_tot;
    logic                    record;

    assign parent = (ptr_reg - NW'(1)) >> 1;
    assign lchild = {ptr_reg[NW-2:0], 1'b1};
    assign rchild = lchild + NW'(1);
    assign leaf_off = LIW'(ptr_reg - BASE);
    assign f_leaf = (leaf_off > n_m1) ? n_m1 : leaf_off;
    assign x_clamp = (32'(x_rank) >= LEAVES) ? LIW'(LEAVES - 1) : LIW'(x_rank);

    assign csum  = {1'b0, rd_a_reg.cnt} + {1'b0, rd_b_reg.cnt};
    assign lb    = rd_a_reg.best;
    assign rbest = rd_a_reg.total + rd_b_reg.best;
    assign delta = SUM_W'(loss_reg) - SUM_W'(zeta);
    assign record = gend_reg && (!found_reg || rd_a_reg.best < bval_reg);

    assign stat.clr_end = (ptr_reg == LAST_IDX);
    assign stat.at_root = (ptr_reg == '0);
    assign stat.at_leaf = (ptr_reg >= BASE);
    assign stat.record  = record;
    assign stat.last    = last_reg;

    always_comb
    begin
        ra       = ptr_reg;
        rb       = rchild;
        we       = 1'b0;
        wa       = ptr_reg;
        wd       = '0;
        ptr_next = ptr_reg;
        dir_next = dir_reg;
        leaf_tot = '0;
        case (cmd.op)
            OP_LOAD:     ptr_next = '0;
            OP_CLR:
            begin
                we       = 1'b1;
                ptr_next = ptr_reg + NW'(1);
            end
            OP_ETA_SET:
            begin
                ptr_next = BASE + NW'(n_m1);
                dir_next = 1'b1;
            end
            OP_ETA:
            begin
                we       = 1'b1;
                wd.total = neg_eta;
                wd.best  = neg_eta;
                wd.cut   = dir_reg;
                dir_next = ~ptr_reg[0];
                ptr_next = parent;
            end
            OP_INS_SET:  ptr_next = BASE + NW'(x_reg);
            OP_INS_WR:
            begin
                we       = 1'b1;
                leaf_tot = rd_a_reg.total + delta;
                wd.cnt   = (rd_a_reg.cnt == CNT_MAX) ? CNT_MAX : rd_a_reg.cnt + CNT_W'(1);
                wd.total = leaf_tot;
                wd.best  = leaf_tot;
                wd.cut   = 1'b1;
            end
            OP_LST_WR:
            begin
                we       = 1'b1;
                leaf_tot = rd_a_reg.total + neg_eta;
                wd.cnt   = rd_a_reg.cnt;
                wd.total = leaf_tot;
                wd.best  = leaf_tot;
                wd.cut   = rd_a_reg.cut;
            end
            OP_UP_RD:
            begin
                ra       = {parent[NW-2:0], 1'b1};
                rb       = {parent[NW-2:0], 1'b1} + NW'(1);
                ptr_next = parent;
            end
            OP_UP_WR:
            begin
                we       = 1'b1;
                wd.cnt   = csum[CNT_W] ? CNT_MAX : csum[CNT_W-1:0];
                wd.total = rd_a_reg.total + rd_b_reg.total;
                if (rd_a_reg.cnt == '0 || rbest < lb)
                begin
                    wd.best = rbest;
                    wd.cut  = 1'b1;
                end
                else
                begin
                    wd.best = lb;
                    wd.cut  = 1'b0;
                end
            end
            OP_FIND_SET: ptr_next = '0;
            OP_FIND_RD:  ra = lchild;
            OP_FIND_STEP: ptr_next = (rd_a_reg.cnt != '0) ? lchild : rchild;
            OP_LST_SET:  ptr_next = BASE + NW'(f_leaf);
            OP_ROOT_RD:  ra = '0;
            OP_ROOT_CHK: if (record) ptr_next = '0;
            OP_DOWN_STEP: ptr_next = rd_a_reg.cut ? rchild : lchild;
            default:     ptr_next = ptr_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_a_reg <= mem[ra];
        rd_b_reg <= mem[rb];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            dir_reg   <= 1'b0;
            found_reg <= 1'b0;
            bval_reg  <= '0;
            bx_reg    <= '0;
            by_reg    <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            dir_reg <= dir_next;
            if (cmd.op == OP_LOAD && first_item)
            begin
                found_reg <= 1'b0;
                bval_reg  <= '0;
                bx_reg    <= '0;
                by_reg    <= '0;
            end
            if (cmd.op == OP_ROOT_CHK && record)
            begin
                found_reg <= 1'b1;
                bval_reg  <= rd_a_reg.best;
                by_reg    <= (32'(y_reg) > 32'(n_m1)) ? RANK_W'(n_m1) : y_reg;
            end
            if (cmd.op == OP_DOWN_FIN)
                bx_reg <= RANK_W'(f_leaf);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            x_reg    <= x_clamp;
            y_reg    <= y_pos;
            loss_reg <= loss_value;
            gend_reg <= group_end;
            last_reg <= last_item;
        end
        if (cmd.op == OP_ROOT_CHK)
            root_reg <= rd_a_reg.best;
    end

    assign root_best     = root_reg;
    assign optimum       = bval_reg;
    assign optimum_valid = found_reg;
    assign best_x_rank   = bx_reg;
    assign best_y_pos    = by_reg;
    assign done_res      = last_reg;

endmodule

@@ hdl/min_prefix_segment_tree_split_top.sv @@
// Channel   Signals                                         Handshake
// input     x_rank y_pos loss_value group_end first/last    start & !busy
// result    root_best optimum optimum_valid best_x_rank     res_valid, one cycle
//           best_y_pos done_res
// config    cfg_index cfg_data                              cfg_valid & cfg_ready
//
// An item updates its leaf, walks up to the root and checks the root for a new optimum;
// the up walk reads both children together and writes the parent in the next cycle.
// A last item adds a descent to the first occupied leaf and a second up walk; a
// recorded optimum adds a descent along the cut bits to the best leaf. A first item
// adds a clearing pass over all 2P-1 nodes, P the leaf count of the tree (the power
// of two at or above LEAVES), and a write of the penalty path. Reset runs a clearing
// pass with busy high; config writes are always taken. Results cannot be stalled.
module min_prefix_segment_tree_split_top
    import mpst_pkg::*;
#(
    parameter int LEAVES = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [RANK_W-1:0]          x_rank,
    input  logic [RANK_W-1:0]          y_pos,
    input  logic signed [DATA_W-1:0]   loss_value,
    input  logic                       group_end,
    input  logic                       first_item,
    input  logic                       last_item,
    output logic                       res_valid,
    output logic signed [SUM_W-1:0]    root_best,
    output logic signed [SUM_W-1:0]    optimum,
    output logic                       optimum_valid,
    output logic [RANK_W-1:0]          best_x_rank,
    output logic [RANK_W-1:0]          best_y_pos,
    output logic                       done_res,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [DATA_W-1:0]          cfg_data
);

    localparam int LIW = $clog2(2**$clog2(LEAVES));

    logic [CNT_W-1:0]         leaf_count_reg;
    logic signed [DATA_W-1:0] zeta_reg, eta_reg;
    logic [LIW-1:0]           n_m1;
    logic signed [SUM_W-1:0]  neg_eta;
    cmd_t                     cmd;
    stat_t                    stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_count_reg <= CNT_W'(1024);
            zeta_reg       <= '0;
            eta_reg        <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LEAF_COUNT: leaf_count_reg <= cfg_data[CNT_W-1:0];
                CFG_ZETA:       zeta_reg       <= cfg_data;
                CFG_ETA:        eta_reg        <= cfg_data;
                default:        leaf_count_reg <= leaf_count_reg;
            endcase
        end
    end

    always_comb
    begin
        if (leaf_count_reg == '0)
            n_m1 = '0;
        else if (32'(leaf_count_reg) > LEAVES)
            n_m1 = LIW'(LEAVES - 1);
        else
            n_m1 = LIW'(leaf_count_reg - CNT_W'(1));
    end

    assign neg_eta = SUM_W'(0) - SUM_W'(eta_reg);

    mpst_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .first_item (first_item),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy),
        .res_valid  (res_valid)
    );

    mpst_dp #(
        .LEAVES (LEAVES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .x_rank        (x_rank),
        .y_pos         (y_pos),
        .loss_value    (loss_value),
        .group_end     (group_end),
        .first_item    (first_item),
        .last_item     (last_item),
        .n_m1          (n_m1),
        .zeta          (zeta_reg),
        .neg_eta       (neg_eta),
        .root_best     (root_best),
        .optimum       (optimum),
        .optimum_valid (optimum_valid),
        .best_x_rank   (best_x_rank),
        .best_y_pos    (best_y_pos),
        .done_res      (done_res)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after accept");

    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> busy)
        else $error("result strobe outside busy");

    a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> !busy)
        else $error("busy held after result");

    a_opt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(optimum_valid) |-> $past(start && !busy && first_item))
        else $error("optimum dropped without first item");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench
    import mpst_pkg::*;
();

    localparam int LEAVES    = 1024;
    localparam int NODES     = 2 * LEAVES - 1;
    localparam int BASE      = LEAVES - 1;
    localparam int CYCLE_CAP = 3000000;

    typedef struct {
        logic [RANK_W-1:0]        x;
        logic [RANK_W-1:0]        y;
        logic signed [DATA_W-1:0] loss;
        logic                     gend;
        logic                     first;
        logic                     last;
    } obs_t;

    typedef struct {
        logic signed [SUM_W-1:0] root;
        logic signed [SUM_W-1:0] opt;
        logic                    opt_ok;
        logic [RANK_W-1:0]       bx;
        logic [RANK_W-1:0]       by;
        logic                    done;
    } split_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [RANK_W-1:0] x_rank = '0;
    logic [RANK_W-1:0] y_pos = '0;
    logic signed [DATA_W-1:0] loss_value = '0;
    logic group_end = 1'b0;
    logic first_item = 1'b0;
    logic last_item = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LEAF_COUNT;
    logic [DATA_W-1:0] cfg_data = '0;
    logic busy;
    logic res_valid;
    logic signed [SUM_W-1:0] root_best;
    logic signed [SUM_W-1:0] optimum;
    logic optimum_valid;
    logic [RANK_W-1:0] best_x_rank;
    logic [RANK_W-1:0] best_y_pos;
    logic done_res;
    logic cfg_ready;

    min_prefix_segment_tree_split_top #(.LEAVES(LEAVES)) dut (.*);

    always #10 clk = ~clk;

    logic [CNT_W-1:0]        cnt_r;
    logic signed [DATA_W-1:0] zeta_r;
    logic signed [DATA_W-1:0] eta_r;

    logic [CNT_W-1:0]        t_cnt [0:NODES-1];
    logic signed [SUM_W-1:0] t_tot [0:NODES-1];
    logic signed [SUM_W-1:0] t_best [0:NODES-1];
    logic                    t_cut [0:NODES-1];
    logic signed [SUM_W-1:0] rec_value;
    logic                    rec_found;
    logic [RANK_W-1:0]       rec_x;
    logic [RANK_W-1:0]       rec_y;

    obs_t   obs_fifo[$];
    split_t split_fifo[$];
    obs_t   cur;
    int     gap_left = 0;
    bit     bursts_on = 1'b1;
    int     errors = 0;
    int     cycles = 0;

    function automatic int leaves_used();
        int n;
        n = int'(cnt_r);
        if (n == 0) n = 1;
        if (n > LEAVES) n = LEAVES;
        return n;
    endfunction

    function automatic void refresh_path(int node);
        int l;
        int r;
        int c;
        logic signed [SUM_W-1:0] lb;
        logic signed [SUM_W-1:0] rb;
        while (node > 0)
        begin
            node = (node - 1) / 2;
            l = 2 * node + 1;
            r = l + 1;
            c = int'(t_cnt[l]) + int'(t_cnt[r]);
            t_cnt[node] = (c > 2047) ? 11'd2047 : c[CNT_W-1:0];
            t_tot[node] = t_tot[l] + t_tot[r];
            lb = t_best[l];
            rb = t_tot[l] + t_best[r];
            if (t_cnt[l] == 0 || rb < lb)
            begin
                t_best[node] = rb;
                t_cut[node] = 1'b1;
            end
            else
            begin
                t_best[node] = lb;
                t_cut[node] = 1'b0;
            end
        end
    endfunction

    function automatic split_t tree_insert(obs_t o);
        split_t s;
        int n;
        int node;
        int c;
        int leaf;
        int b;
        logic dir;
        logic signed [SUM_W-1:0] neg_eta;
        logic signed [SUM_W-1:0] dl;
        logic signed [SUM_W-1:0] dz;
        n = leaves_used();
        neg_eta = SUM_W'(eta_r);
        neg_eta = -neg_eta;
        if (o.first)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                t_cnt[i] = '0;
                t_tot[i] = '0;
                t_best[i] = '0;
                t_cut[i] = 1'b0;
            end
            rec_value = '0;
            rec_found = 1'b0;
            rec_x = '0;
            rec_y = '0;
            node = BASE + n - 1;
            dir = 1'b1;
            forever
            begin
                t_tot[node] = neg_eta;
                t_best[node] = neg_eta;
                t_cut[node] = dir;
                if (node == 0) break;
                dir = ((node - 1) % 2) == 1;
                node = (node - 1) / 2;
            end
        end
        node = BASE + int'(o.x);
        c = int'(t_cnt[node]) + 1;
        t_cnt[node] = (c > 2047) ? 11'd2047 : c[CNT_W-1:0];
        dl = SUM_W'(o.loss);
        dz = SUM_W'(zeta_r);
        t_tot[node] = t_tot[node] + (dl - dz);
        t_best[node] = t_tot[node];
        t_cut[node] = 1'b1;
        refresh_path(node);
        if (o.last)
        begin
            leaf = 0;
            while (leaf < n - 1 && t_cnt[BASE + leaf] == 0) leaf++;
            node = BASE + leaf;
            t_tot[node] = t_tot[node] + neg_eta;
            t_best[node] = t_tot[node];
            refresh_path(node);
        end
        if (o.gend && (!rec_found || t_best[0] < rec_value))
        begin
            rec_value = t_best[0];
            rec_found = 1'b1;
            b = 0;
            while (b < BASE) b = 2 * b + 1 + int'(t_cut[b]);
            b = b - BASE;
            rec_x = RANK_W'((b >= n) ? n - 1 : b);
            rec_y = RANK_W'((int'(o.y) >= n) ? n - 1 : int'(o.y));
        end
        s.root = t_best[0];
        s.opt = rec_value;
        s.opt_ok = rec_found;
        s.bx = rec_x;
        s.by = rec_y;
        s.done = o.last;
        return s;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy) split_fifo.push_back(tree_insert(cur));
            if (start && busy)
            begin
                // hold
            end
            else if (gap_left > 0)
            begin
                if (!busy) gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (obs_fifo.size() != 0)
            begin
                cur = obs_fifo.pop_front();
                x_rank <= cur.x;
                y_pos <= cur.y;
                loss_value <= cur.loss;
                group_end <= cur.gend;
                first_item <= cur.first;
                last_item <= cur.last;
                start <= 1'b1;
                if (bursts_on && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 6);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        split_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("TEST FAILED");
            $finish;
        end
        if (rst_n && res_valid)
        begin
            if (split_fifo.size() == 0)
            begin
                $display("%0t: unexpected word root_best=%0d", $time, root_best);
                errors <= errors + 1;
            end
            else
            begin
                e = split_fifo.pop_front();
                if (root_best !== e.root || optimum !== e.opt || optimum_valid !== e.opt_ok
                    || best_x_rank !== e.bx || best_y_pos !== e.by || done_res !== e.done)
                begin
                    $display("%0t: expected root=%0d opt=%0d ok=%0b x=%0d y=%0d done=%0b",
                             $time, e.root, e.opt, e.opt_ok, e.bx, e.by, e.done);
                    $display("%0t:   actual root=%0d opt=%0d ok=%0b x=%0d y=%0d done=%0b",
                             $time, root_best, optimum, optimum_valid, best_x_rank,
                             best_y_pos, done_res);
                    errors <= errors + 1;
                end
            end
        end
    end

    task automatic add_obs(int x, int y, logic signed [DATA_W-1:0] loss, bit ge, bit fi, bit la);
        obs_t o;
        o.x = RANK_W'(x);
        o.y = RANK_W'(y);
        o.loss = loss;
        o.gend = ge;
        o.first = fi;
        o.last = la;
        obs_fifo.push_back(o);
    endtask

    function automatic logic signed [DATA_W-1:0] rand_loss();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
    endfunction

    task automatic add_run(int len);
        int n;
        int y;
        int x;
        bit ge;
        n = leaves_used();
        y = $urandom_range(0, 2) == 0 ? $urandom_range(0, 1023) : 0;
        for (int i = 0; i < len; i++)
        begin
            x = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, n - 1);
            ge = (i == len - 1) ? 1'b1 : $urandom_range(0, 2) != 0;
            add_obs(x, y & 10'h3ff, rand_loss(), ge, i == 0, i == len - 1);
            if (ge) y++;
        end
    endtask

    task automatic add_noise();
        add_obs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom,
                $urandom_range(0, 1) == 1, $urandom_range(0, 7) == 0,
                $urandom_range(0, 7) == 0);
    endtask

    task automatic drain();
        do @(posedge clk);
        while (start || busy || obs_fifo.size() != 0 || split_fifo.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_LEAF_COUNT: cnt_r = data[CNT_W-1:0];
            CFG_ZETA:       zeta_r = data;
            CFG_ETA:        eta_r = data;
            default: ;
        endcase
    endtask

    task automatic set_regs(int n, logic [DATA_W-1:0] z, logic [DATA_W-1:0] e);
        @(posedge clk);
        write_reg(CFG_LEAF_COUNT, n);
        write_reg(CFG_ZETA, z);
        write_reg(CFG_ETA, e);
        cfg_valid <= 1'b0;
    endtask

    int ph_n [8] = '{1, 2, 0, 2047, 37, 1024, 300, 16};

    initial
    begin
        int goal;
        cnt_r = 11'd1024;
        zeta_r = '0;
        eta_r = '0;
        for (int i = 0; i < NODES; i++)
        begin
            t_cnt[i] = '0;
            t_tot[i] = '0;
            t_best[i] = '0;
            t_cut[i] = 1'b0;
        end
        rec_value = '0;
        rec_found = 1'b0;
        rec_x = '0;
        rec_y = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        add_obs(0, 0, 32'sh7fffffff, 1, 0, 0);
        add_obs(1023, 1, 32'sh80000000, 1, 0, 0);
        add_obs(512, 2, 0, 0, 0, 0);
        add_obs(512, 2, 0, 1, 0, 1);
        add_obs(1023, 0, 32'sh00010000, 1, 1, 1);
        add_obs(3, 0, 32'sh00010000, 0, 1, 0);
        add_obs(5, 0, -32'sh00010000, 1, 0, 0);
        add_obs(4, 1, 0, 1, 0, 0);
        add_obs(6, 2, 0, 1, 0, 0);
        add_obs(700, 1023, 32'sh80000000, 1, 0, 1);
        drain();
        set_regs(4, 32'h0000_8000, 32'h0002_0000);
        add_obs(2, 5, 32'sh0001_0000, 1, 1, 0);
        add_obs(900, 9, -32'sh0003_0000, 1, 0, 0);
        add_obs(3, 1023, 32'sh0000_8000, 1, 0, 1);
        drain();

        foreach (ph_n[p])
        begin
            if (p == 3)
                set_regs(ph_n[p], 32'h7fff_ffff, 32'h8000_0000);
            else if (p == 5)
                set_regs(ph_n[p], 32'h8000_0000, 32'h7fff_ffff);
            else
                set_regs(ph_n[p], $urandom_range(0, 6 << 16) - (3 << 16),
                         $urandom_range(0, 6 << 16) - (3 << 16));
            if (p == 7) bursts_on = 1'b0;
            goal = obs_fifo.size() + 130;
            while (obs_fifo.size() < goal)
            begin
                if ($urandom_range(0, 6) == 0) add_noise();
                else add_run($urandom_range(1, 30));
            end
            drain();
        end
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
